>>> hdl/midc_pkg.sv
// Package for the midpoint circle rasterizer: coordinate, pixel and decision widths,
// stream word widths and operation codes.
// No dependencies.
`timescale 1ns / 1ps

package midc_pkg;

  // Coordinate width of the centre, radius and octant point.
  localparam int COORD_BITS = 11;
  // Pixel coordinates carry a sign bit and one carry bit.
  localparam int PIX_BITS   = COORD_BITS + 2;
  // The decision value is held at pixel width, two's complement.
  localparam int DEC_BITS   = PIX_BITS;
  // Working width for one decision update before saturation.
  localparam int SUM_BITS   = DEC_BITS + 2;

  // Eight symmetric pixels per octant point.
  localparam int SET_SIZE = 8;
  localparam int IDX_BITS = $clog2(SET_SIZE);
  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(SET_SIZE - 1);

  // Stream word widths, padded up to whole bytes.
  localparam int IN_TDATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * PIX_BITS + 7) / 8) * 8;

  // Saturation limits of the decision value at the working width.
  localparam logic signed [SUM_BITS-1:0] SUM_DEC_MAX = SUM_BITS'(2 ** (DEC_BITS - 1) - 1);
  localparam logic signed [SUM_BITS-1:0] SUM_DEC_MIN = -SUM_DEC_MAX - SUM_BITS'(1);

  // Operation carried on the input tuser.
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

endpackage

>>> hdl/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer: one octant step per input word, eight pixels per live step.
// Depends on midc_pkg.
//
//   channel | dir | tdata (low bit up)                 | tuser        | tlast
//   in_     | in  | center_x, center_y, radius         | operation    | -
//   out_    | out | pixel_x, pixel_y                   | circle_done  | last_of_set
//
// For a start or live advance word, the eight pixels leave one per cycle when not stalled
// on out_tready, through the output register, counted by a three-bit pixel index over
// the octant state. An advance at the final octant point is taken and gives no pixel.
// The next word is taken in the cycle the eighth pixel moves to the output register,
// so sets follow back to back. A word's pixels are formed from the registered octant state.
// Reset (rst_n low, synchronous) clears the octant point, decision and held centre.
// A stall on out_tready holds the output register and the pixel index.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // center_x [10:0], center_y [21:11], radius [32:22], zero padding above
  input  logic [midc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // operation
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_x [12:0], pixel_y [25:13], zero padding above
  output logic [midc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // circle_done
  output logic                              out_tuser,
  // last_of_set
  output logic                              out_tlast
);

  import midc_pkg::*;

  localparam int EXT_C = PIX_BITS - COORD_BITS;
  localparam int EXT_S = SUM_BITS - COORD_BITS;

  // Octant state
  logic [COORD_BITS-1:0]      octant_x_r, octant_x_nxt;
  logic [COORD_BITS-1:0]      octant_y_r, octant_y_nxt;
  logic signed [DEC_BITS-1:0] decision_r, decision_nxt;
  logic [COORD_BITS-1:0]      center_x_r, center_x_nxt;
  logic [COORD_BITS-1:0]      center_y_r, center_y_nxt;

  // Set emission control
  logic                set_valid_r, set_valid_nxt;
  logic [IDX_BITS-1:0] pix_idx_r, pix_idx_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [PIX_BITS-1:0] pix_x_r, pix_x_nxt;
  logic [PIX_BITS-1:0] pix_y_r, pix_y_nxt;
  logic                last_r, last_nxt;
  logic                done_r, done_nxt;

  // Input fields
  op_t                 in_op;
  logic [COORD_BITS-1:0] in_cx, in_cy, in_radius;

  logic out_free, set_move, set_finish, in_acc, set_load, at_end;

  logic signed [SUM_BITS-1:0] dec_ext, x_inc_ext, y_dec_ext, r_ext, dec_sum;
  logic [COORD_BITS-1:0]      x_inc, y_dec;

  logic [PIX_BITS-1:0] cx_p, cy_p, a_p, b_p;

  // Clamp a working-width decision value into the held range.
  function automatic logic signed [DEC_BITS-1:0] sat_dec(input logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] c;
    begin
      if (v > SUM_DEC_MAX) begin
        c = SUM_DEC_MAX;
      end else if (v < SUM_DEC_MIN) begin
        c = SUM_DEC_MIN;
      end else begin
        c = v;
      end
      return c[DEC_BITS-1:0];
    end
  endfunction

  // Unpack the input word.
  assign in_op     = op_t'(in_tuser);
  assign in_cx     = in_tdata[COORD_BITS-1:0];
  assign in_cy     = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_radius = in_tdata[3*COORD_BITS-1:2*COORD_BITS];

  // Handshake: a word is taken when no set is pending or the last pixel is moving out.
  assign out_free   = !out_valid_r || out_tready;
  assign set_move   = set_valid_r && out_free;
  assign set_finish = set_move && (pix_idx_r == IDX_LAST);
  assign in_tready  = !set_valid_r || set_finish;
  assign in_acc     = in_tvalid && in_tready;
  assign at_end     = octant_x_r >= octant_y_r;
  assign set_load   = in_acc && ((in_op == OP_START) || !at_end);

  // Decision update terms.
  assign x_inc     = octant_x_r + COORD_BITS'(1);
  assign y_dec     = octant_y_r - COORD_BITS'(1);
  assign dec_ext   = SUM_BITS'(decision_r);
  assign x_inc_ext = $signed({{EXT_S{1'b0}}, x_inc});
  assign y_dec_ext = $signed({{EXT_S{1'b0}}, y_dec});
  assign r_ext     = $signed({{EXT_S{1'b0}}, in_radius});

  always_comb begin
    if (decision_r < 0) begin
      dec_sum = dec_ext + (x_inc_ext <<< 1) + SUM_BITS'(1);
    end else begin
      dec_sum = dec_ext + ((x_inc_ext - y_dec_ext) <<< 1) + SUM_BITS'(1);
    end
  end

  // Next octant state on an accepted word.
  always_comb begin
    octant_x_nxt = octant_x_r;
    octant_y_nxt = octant_y_r;
    decision_nxt = decision_r;
    center_x_nxt = center_x_r;
    center_y_nxt = center_y_r;
    if (in_acc) begin
      if (in_op == OP_START) begin
        center_x_nxt = in_cx;
        center_y_nxt = in_cy;
        octant_x_nxt = '0;
        octant_y_nxt = in_radius;
        decision_nxt = sat_dec(SUM_BITS'(1) - r_ext);
      end else if (!at_end) begin
        octant_x_nxt = x_inc;
        decision_nxt = sat_dec(dec_sum);
        if (decision_r >= 0) begin
          octant_y_nxt = y_dec;
        end
      end
    end
  end

  // Pixel index: bit 0 negates the x offset, bit 1 the y offset, bit 2 swaps them.
  assign cx_p = {{EXT_C{1'b0}}, center_x_r};
  assign cy_p = {{EXT_C{1'b0}}, center_y_r};
  assign a_p  = pix_idx_r[2] ? {{EXT_C{1'b0}}, octant_y_r} : {{EXT_C{1'b0}}, octant_x_r};
  assign b_p  = pix_idx_r[2] ? {{EXT_C{1'b0}}, octant_x_r} : {{EXT_C{1'b0}}, octant_y_r};

  // Set and output register control.
  always_comb begin
    set_valid_nxt = set_valid_r;
    pix_idx_nxt   = pix_idx_r;
    out_valid_nxt = out_valid_r;
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    if (set_move) begin
      pix_idx_nxt   = pix_idx_r + IDX_BITS'(1);
      out_valid_nxt = 1'b1;
      pix_x_nxt     = pix_idx_r[0] ? (cx_p - a_p) : (cx_p + a_p);
      pix_y_nxt     = pix_idx_r[1] ? (cy_p - b_p) : (cy_p + b_p);
      last_nxt      = (pix_idx_r == IDX_LAST);
      done_nxt      = at_end;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (set_finish) begin
      set_valid_nxt = 1'b0;
    end
    if (set_load) begin
      set_valid_nxt = 1'b1;
      pix_idx_nxt   = '0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octant_x_r  <= '0;
      octant_y_r  <= '0;
      decision_r  <= '0;
      center_x_r  <= '0;
      center_y_r  <= '0;
      set_valid_r <= 1'b0;
      pix_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      octant_x_r  <= octant_x_nxt;
      octant_y_r  <= octant_y_nxt;
      decision_r  <= decision_nxt;
      center_x_r  <= center_x_nxt;
      center_y_r  <= center_y_nxt;
      set_valid_r <= set_valid_nxt;
      pix_idx_r   <= pix_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    pix_x_r <= pix_x_nxt;
    pix_y_r <= pix_y_nxt;
    last_r  <= last_nxt;
    done_r  <= done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2 * PIX_BITS){1'b0}}, pix_y_r, pix_x_r};
  assign out_tuser  = done_r;
  assign out_tlast  = last_r;

`ifndef SYNTH
  // A set that has not reached its eighth pixel stays pending.
  a_set_holds: assert property (@(posedge clk) disable iff (!rst_n)
    set_valid_r && (pix_idx_r != IDX_LAST) |=> set_valid_r)
    else $error("pixel set dropped before its eighth pixel");

  // A new word is only taken with no set pending or as the eighth pixel leaves.
  a_ready_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && set_valid_r |-> (pix_idx_r == IDX_LAST) && out_free)
    else $error("input taken while a pixel set is still being emitted");

  // Octant state is frozen while a set is being emitted.
  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    set_valid_r && !set_finish |=> $stable(octant_x_r) && $stable(octant_y_r)
                                    && $stable(decision_r))
    else $error("octant point changed during pixel emission");

  // The eighth pixel of a set carries the last marker.
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    set_finish |=> out_tvalid && out_tlast)
    else $error("eighth pixel without last marker");
`endif

endmodule

>>> test/midpoint_circle_rasterizer_test.sv
// Self-checking testbench for the midpoint circle rasterizer: a directed table, then random
// circles, every pixel word compared against a behavioural octant walker or a typed row.
// Depends on midc_pkg and midpoint_circle_rasterizer.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_test;
  import midc_pkg::*;

  localparam int CMAX      = (1 << COORD_BITS) - 1;
  localparam int DEC_HI    = (1 << (DEC_BITS - 1)) - 1;
  localparam int DEC_LO    = -DEC_HI - 1;
  localparam int ITEM_GOAL = 370;
  localparam int PLAN_LEN  = 25;

  typedef struct packed {
    logic [PIX_BITS-1:0] px;
    logic [PIX_BITS-1:0] py;
    logic                last;
    logic                done;
  } pixel_t;

  // One directed word, with an optional hand-written expectation: every pixel of the set at
  // (px, py), or no pixel at all when n is zero.
  typedef struct packed {
    op_t                   op;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] rad;
    logic                  typed;
    logic [3:0]            n;
    logic [PIX_BITS-1:0]   px;
    logic [PIX_BITS-1:0]   py;
    logic                  done;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  midpoint_circle_rasterizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Octant walker state, mirrored from the block.
  int oct_x = 0;
  int oct_y = 0;
  int dec_val = 0;
  int ctr_x = 0;
  int ctr_y = 0;

  pixel_t step_pixels [8];
  pixel_t pending_pixels [$];

  int  fault_count = 0;
  int  pixels_checked = 0;
  int  start_words = 0;
  int  advance_words = 0;
  int  silent_advances = 0;
  int  productive = 0;
  bit  quiet = 1'b0;
  bit  drain_hold = 1'b0;

  // The directed words: advances before any start and past the final point, radius zero,
  // coordinate extremes, the smallest live circle and alternating bit patterns.
  plan_row_t plan [PLAN_LEN] = '{
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b1, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_START,   11'd5,    11'd7,    11'd0,    1'b1, 4'd8, 13'd5,    13'd7,    1'b1},
    '{OP_ADVANCE, 11'd2047, 11'd2047, 11'd2047, 1'b1, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_START,   11'd0,    11'd0,    11'd0,    1'b1, 4'd8, 13'd0,    13'd0,    1'b1},
    '{OP_START,   11'd2047, 11'd2047, 11'd0,    1'b1, 4'd8, 13'd2047, 13'd2047, 1'b1},
    '{OP_START,   11'd0,    11'd0,    11'd2047, 1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_START,   11'd2047, 11'd2047, 11'd2047, 1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_START,   11'd1024, 11'd1024, 11'd1,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b1, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_START,   11'd100,  11'd200,  11'd5,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_START,   11'd1365, 11'd682,  11'd10,   1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd682,  11'd1365, 11'd1365, 1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_ADVANCE, 11'd0,    11'd0,    11'd0,    1'b0, 4'd0, 13'd0,    13'd0,    1'b0},
    '{OP_START,   11'd3,    11'd2,    11'd2047, 1'b0, 4'd0, 13'd0,    13'd0,    1'b0}
  };

  function automatic int clamp_dec(input int v);
    if (v > DEC_HI) return DEC_HI;
    if (v < DEC_LO) return DEC_LO;
    return v;
  endfunction

  // Coordinates lean towards the two ends of the range.
  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COORD_BITS'($urandom_range(0, CMAX));
    endcase
  endfunction

  // Walks the octant for one accepted word and fills step_pixels with the set it gives.
  task automatic step_model(input op_t op, input int cx, input int cy, input int rad,
                            output int n);
    int  sx [8];
    int  sy [8];
    bit  fin;
    n = 0;
    if (op == OP_START) begin
      ctr_x   = cx;
      ctr_y   = cy;
      oct_x   = 0;
      oct_y   = rad;
      dec_val = clamp_dec(1 - rad);
    end else begin
      // Nothing moves once the point has reached the diagonal.
      if (oct_x >= oct_y) return;
      oct_x = oct_x + 1;
      if (dec_val < 0) begin
        dec_val = clamp_dec(dec_val + 2 * oct_x + 1);
      end else begin
        oct_y   = oct_y - 1;
        dec_val = clamp_dec(dec_val + 2 * (oct_x - oct_y) + 1);
      end
    end
    // Reflect the point into the eight octants, in the block's order.
    sx = '{oct_x, -oct_x, oct_x, -oct_x, oct_y, -oct_y, oct_y, -oct_y};
    sy = '{oct_y, oct_y, -oct_y, -oct_y, oct_x, oct_x, -oct_x, -oct_x};
    fin = (oct_x >= oct_y);
    for (int k = 0; k < 8; k++) begin
      step_pixels[k].px   = PIX_BITS'(ctr_x + sx[k]);
      step_pixels[k].py   = PIX_BITS'(ctr_y + sy[k]);
      step_pixels[k].last = (k == 7);
      step_pixels[k].done = fin;
    end
    n = 8;
  endtask

  task automatic queue_set(input int n);
    for (int k = 0; k < n; k++) pending_pixels.push_back(step_pixels[k]);
    if (n > 0) productive++;
    else silent_advances++;
  endtask

  // Offers one word and returns at the edge where it is taken. Called at a rising edge.
  task automatic offer_word(input op_t op, input logic [COORD_BITS-1:0] cx,
                            input logic [COORD_BITS-1:0] cy, input logic [COORD_BITS-1:0] rad);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({rad, cy, cx});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_START) start_words++;
    else advance_words++;
  endtask

  task automatic issue(input op_t op, input logic [COORD_BITS-1:0] cx,
                       input logic [COORD_BITS-1:0] cy, input logic [COORD_BITS-1:0] rad);
    int n;
    offer_word(op, cx, cy, rad);
    step_model(op, cx, cy, rad, n);
    queue_set(n);
  endtask

  // Stimulus: reset, the directed table, then random circles.
  initial begin
    int  n;
    int  pick;
    int  limit;
    bit  broken;
    bit  held_off;
    bit  paused;
    logic [COORD_BITS-1:0] rad;
    held_off = 1'b0;
    paused   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_START;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      offer_word(plan[i].op, plan[i].cx, plan[i].cy, plan[i].rad);
      step_model(plan[i].op, plan[i].cx, plan[i].cy, plan[i].rad, n);
      if (plan[i].typed) begin
        n = plan[i].n;
        for (int k = 0; k < 8; k++) begin
          step_pixels[k].px   = plan[i].px;
          step_pixels[k].py   = plan[i].py;
          step_pixels[k].last = (k == 7);
          step_pixels[k].done = plan[i].done;
        end
      end
      queue_set(n);
    end

    // Mostly whole circles; some are cut short by a new start, some advances are stray.
    while (productive < ITEM_GOAL) begin
      if (!held_off && productive >= 120) begin
        drain_hold = 1'b1;
        held_off   = 1'b1;
      end
      if (!paused && productive >= 220) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_pixels.size() != 0);
        paused = 1'b1;
      end
      if (productive >= ITEM_GOAL - 50) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) issue(OP_ADVANCE, rand_coord(), rand_coord(), rand_coord());
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        rad    = COORD_BITS'($urandom_range(1000, CMAX));
        broken = 1'b1;
      end else if (pick < 5) begin
        rad    = COORD_BITS'($urandom_range(21, 200));
        broken = ($urandom_range(0, 1) == 0);
      end else begin
        rad    = COORD_BITS'($urandom_range(0, 20));
        broken = ($urandom_range(0, 6) == 0);
      end
      issue(OP_START, rand_coord(), rand_coord(), rad);
      limit = broken ? $urandom_range(1, 8) : CMAX + 1;
      for (int s = 0; s < limit && oct_x < oct_y && productive < ITEM_GOAL; s++)
        issue(OP_ADVANCE, rand_coord(), rand_coord(), rand_coord());
      if (!broken) repeat ($urandom_range(0, 2))
        issue(OP_ADVANCE, rand_coord(), rand_coord(), rand_coord());
    end

    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d start and %0d advance words (%0d advances gave no pixels).",
             start_words, advance_words, silent_advances);
    $display("Checked %0d pixel words; %0d mismatches.", pixels_checked, fault_count);
    if (fault_count == 0) begin
      $display("PASS midpoint_circle_rasterizer");
    end else begin
      $display("FAIL midpoint_circle_rasterizer");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, and none in the final stretch.
  initial begin
    forever begin
      if (drain_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        drain_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Each pixel word taken is compared with the oldest expected pixel.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.px   = out_tdata[PIX_BITS-1:0];
      got.py   = out_tdata[2*PIX_BITS-1:PIX_BITS];
      got.last = out_tlast;
      got.done = out_tuser;
      if (pending_pixels.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: unexpected pixel x=%0d y=%0d last=%0b done=%0b", $realtime,
                   $signed(got.px), $signed(got.py), got.last, got.done);
        fault_count++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (got !== want) begin
          if (fault_count < 10)
            $display({"%0t: pixel mismatch, expected x=%0d y=%0d last=%0b done=%0b, ",
                      "got x=%0d y=%0d last=%0b done=%0b"},
                     $realtime, $signed(want.px), $signed(want.py), want.last, want.done,
                     $signed(got.px), $signed(got.py), got.last, got.done);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #4000000;
    $display("Timed out with %0d pixels still expected.", pending_pixels.size());
    $display("FAIL midpoint_circle_rasterizer");
    $finish;
  end

endmodule
